// ===== src/nda_pkg.sv =====
// Shared types, constants and helpers for the node discovery id assigner.
// Used by nda_cell, nda_ctrl and node_discovery_id_assigner_unit.
package nda_pkg;

  localparam int NODE_SLOTS = 32;
  localparam int SLOT_W = $clog2(NODE_SLOTS);

  localparam logic [7:0] CMD_REQUEST = 8'hF0;
  localparam logic [7:0] CMD_ACK = 8'hF2;
  localparam logic [7:0] MAGIC_A = 8'hAA;
  localparam logic [7:0] MAGIC_B = 8'h55;
  localparam logic [10:0] HELLO_BASE = 11'h700;
  localparam logic [5:0] ID_LOW = 6'd1;
  localparam logic [5:0] ID_HIGH = 6'd32;
  localparam logic [5:0] MAX_NODES_RST = 6'd32;
  localparam logic [7:0] DEV_TYPE_RST = 8'd3;

  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic [1:0] EV_QUERY = 2'd0;
  localparam logic [1:0] EV_ASSIGN = 2'd1;
  localparam logic [1:0] EV_CONFIRM = 2'd2;
  localparam logic [1:0] EV_READ = 2'd3;

  localparam logic REG_MAX_NODES = 1'b0;
  localparam logic REG_DEV_TYPE = 1'b1;

  typedef struct packed {
    logic [15:0] token;
    logic [5:0]  id;
    logic        ready;
    logic [7:0]  fw;
    logic [7:0]  caps;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_WRITE, S_OUT
  } state_t;

  function automatic logic [5:0] pick_id(input logic [31:0] taken);
    logic [5:0] r;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      if (!taken[i]) r = 6'(i + 1);
    end
    return r;
  endfunction

endpackage

// ===== src/nda_cell.sv =====
// One node table entry of the rotating ring of cells.
// Depends on nda_pkg for the entry type.
module nda_cell (
  input  logic            clk,
  input  logic            shift_en,
  input  nda_pkg::entry_t d_in,
  output nda_pkg::entry_t q
);
  import nda_pkg::*;

  entry_t ent_r;

  always_ff @(posedge clk) begin
    if (shift_en) ent_r <= d_in;
  end

  assign q = ent_r;

endmodule

// ===== src/nda_ctrl.sv =====
// Sequencer at the head of the cell ring: scans entries, decides, writes back.
// Holds configuration, fill count, query sequence and the result register.
// Depends on nda_pkg.
module nda_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_kind,
  input  logic [10:0]     in_frame_id,
  input  logic [3:0]      in_frame_len,
  input  logic [7:0]      in_byte0,
  input  logic [7:0]      in_byte1,
  input  logic [7:0]      in_byte2,
  input  logic [7:0]      in_byte3,
  input  logic [7:0]      in_byte4,
  input  logic [7:0]      in_byte5,
  input  logic [7:0]      in_byte6,
  input  logic [7:0]      in_byte7,
  input  logic [4:0]      in_slot,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  logic [7:0]      cfg_data,
  input  nda_pkg::entry_t head,
  output nda_pkg::entry_t head_in,
  output logic            shift_en,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      out_event_res,
  output logic [7:0]      out_sequence_res,
  output logic [4:0]      out_entry,
  output logic [5:0]      out_node_id,
  output logic [15:0]     out_node_token,
  output logic            out_is_ready,
  output logic [7:0]      out_firmware,
  output logic [7:0]      out_capabilities,
  output logic [5:0]      out_entries_used
);
  import nda_pkg::*;

  state_t state_r, state_nxt;
  logic [5:0] max_nodes_r;
  logic [7:0] dev_type_r;
  logic [5:0] fill_r;
  logic [7:0] seq_r;
  logic [SLOT_W-1:0] k_r;

  logic is_hello_r, is_ack_r, is_read_r;
  logic [15:0] tok_r;
  logic [7:0] b1_r, b2_r, b3_r, b7_r;
  logic [7:0] hid_r;
  logic [4:0] slot_r;

  logic found_r, hfound_r;
  logic [SLOT_W-1:0] n_r, hn_r;
  entry_t ent_r, hent_r, rd_r;
  logic [31:0] mask_r;

  logic [SLOT_W-1:0] tgt_r;
  entry_t new_r;
  logic wr_r, res_r;
  logic [1:0] ev_r;

  logic in_fire, cfg_fire, out_fire, in_range;
  logic [5:0] lim;

  logic is_hello_c, std_c, is_ack_c, is_req_c;
  logic [15:0] ack_tok, req_tok;

  logic d_wr, d_res, d_add;
  logic [1:0] d_ev;
  logic [SLOT_W-1:0] d_tgt;
  entry_t d_base, d_new;
  logic [5:0] pid;
  logic clash;

  assign in_fire = in_valid && in_ready;
  assign cfg_fire = cfg_valid && cfg_ready;
  assign out_fire = out_valid && out_ready;
  assign cfg_ready = 1'b1;
  assign lim = (max_nodes_r > 6'(NODE_SLOTS)) ? 6'(NODE_SLOTS) : max_nodes_r;
  assign in_range = {1'b0, k_r} < fill_r;

  assign is_hello_c = (in_frame_id >= HELLO_BASE) && (in_frame_len >= 4'd4) &&
                      (in_byte0 == dev_type_r);
  assign std_c = (in_frame_len == 4'd8) && (in_frame_id == 11'd0);
  assign ack_tok = {in_byte5, in_byte4};
  assign req_tok = {in_byte6, in_byte5};
  assign is_ack_c = std_c && in_byte0 == CMD_ACK && in_byte2 == MAGIC_A &&
                    in_byte3 == MAGIC_B && in_byte6 == dev_type_r &&
                    {2'b00, in_byte1[5:0]} == in_byte1 &&
                    in_byte1[5:0] >= ID_LOW && in_byte1[5:0] <= ID_HIGH &&
                    ack_tok != 16'd0;
  assign is_req_c = std_c && !is_ack_c && in_byte0 == CMD_REQUEST &&
                    in_byte1 == dev_type_r && req_tok != 16'd0 &&
                    !(in_byte0 == CMD_ACK);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_kind == KIND_QUERY) state_nxt = S_OUT;
          else if (in_kind == KIND_READ) state_nxt = S_SCAN;
          else if (in_kind == KIND_FRAME && (is_hello_c || is_ack_c || is_req_c))
            state_nxt = S_SCAN;
        end
      end
      S_SCAN: if (k_r == SLOT_W'(NODE_SLOTS - 1)) state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (d_wr) state_nxt = S_WRITE;
        else if (d_res) state_nxt = S_OUT;
        else state_nxt = S_IDLE;
      end
      S_WRITE: begin
        if (k_r == SLOT_W'(NODE_SLOTS - 1)) state_nxt = res_r ? S_OUT : S_IDLE;
      end
      S_OUT: if (out_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == S_IDLE);
    out_valid = (state_r == S_OUT);
    shift_en = (state_r == S_SCAN) || (state_r == S_WRITE);
    head_in = head;
    if (state_r == S_WRITE && wr_r && k_r == tgt_r) head_in = new_r;
  end

  always_comb begin
    d_wr = 1'b0;
    d_res = 1'b0;
    d_add = 1'b0;
    d_ev = EV_READ;
    d_tgt = n_r;
    d_base = ent_r;
    clash = 1'b0;
    if (is_read_r) begin
      d_res = 1'b1;
      d_tgt = slot_r;
      d_base = rd_r;
    end else if (is_hello_r) begin
      d_wr = hfound_r;
      d_tgt = hn_r;
      d_base = hent_r;
      d_base.fw = b2_r;
      d_base.caps = b3_r;
    end else begin
      if (!found_r) begin
        d_tgt = fill_r[SLOT_W-1:0];
        d_base = '{token: tok_r, id: 6'd0, ready: 1'b0, fw: 8'd0, caps: 8'd0};
        d_add = fill_r < lim;
      end
      d_wr = found_r || d_add;
      if (is_ack_r) begin
        clash = mask_r[5'(b1_r - 8'd1)];
        if (!clash) begin
          d_base.id = b1_r[5:0];
          d_base.fw = b7_r;
          d_base.ready = 1'b1;
          d_res = d_wr;
          d_ev = EV_CONFIRM;
        end
      end else begin
        d_base.fw = b2_r;
        d_base.caps = b3_r;
      end
      if ((is_ack_r && clash) || (!is_ack_r && !d_base.ready)) begin
        if (pid != 6'd0) begin
          d_base.id = pid;
          d_base.ready = 1'b0;
          d_res = d_wr;
          d_ev = EV_ASSIGN;
        end
      end
    end
    d_new = d_base;
  end

  assign pid = pick_id(mask_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      max_nodes_r <= MAX_NODES_RST;
      dev_type_r <= DEV_TYPE_RST;
      fill_r <= '0;
      seq_r <= '0;
      k_r <= '0;
      found_r <= 1'b0;
      hfound_r <= 1'b0;
      wr_r <= 1'b0;
      res_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_fire) begin
        case (cfg_index)
          REG_MAX_NODES: max_nodes_r <= cfg_data[5:0];
          REG_DEV_TYPE: dev_type_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire) begin
        k_r <= '0;
        found_r <= 1'b0;
        hfound_r <= 1'b0;
        wr_r <= 1'b0;
        res_r <= 1'b0;
        if (in_kind == KIND_QUERY) seq_r <= seq_r + 8'd1;
      end
      if (shift_en) k_r <= k_r + 1'b1;
      if (state_r == S_SCAN && in_range) begin
        if (!found_r && head.token == tok_r) found_r <= 1'b1;
        if (!hfound_r && head.ready && {2'b00, head.id} == hid_r) hfound_r <= 1'b1;
      end
      if (state_r == S_DECIDE) begin
        wr_r <= d_wr;
        res_r <= d_res;
        if (d_add) fill_r <= fill_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      is_read_r <= (in_kind == KIND_READ);
      is_hello_r <= (in_kind == KIND_FRAME) && is_hello_c;
      is_ack_r <= (in_kind == KIND_FRAME) && !is_hello_c && is_ack_c;
      tok_r <= is_ack_c ? ack_tok : req_tok;
      b1_r <= in_byte1;
      b2_r <= in_byte2;
      b3_r <= in_byte3;
      b7_r <= in_byte7;
      hid_r <= in_frame_id[7:0];
      slot_r <= in_slot;
      mask_r <= '0;
      if (in_kind == KIND_QUERY) begin
        out_event_res <= EV_QUERY;
        out_sequence_res <= seq_r + 8'd1;
        out_entry <= '0;
        out_node_id <= '0;
        out_node_token <= '0;
        out_is_ready <= 1'b0;
        out_firmware <= '0;
        out_capabilities <= '0;
        out_entries_used <= fill_r;
      end
    end
    if (state_r == S_SCAN) begin
      if ({1'b0, k_r} == {1'b0, slot_r}) rd_r <= head;
      if (in_range) begin
        if (!found_r && head.token == tok_r) begin
          n_r <= k_r;
          ent_r <= head;
        end else if (head.id >= ID_LOW && head.id <= ID_HIGH) begin
          mask_r[5'(head.id - 6'd1)] <= 1'b1;
        end
        if (!hfound_r && head.ready && {2'b00, head.id} == hid_r) begin
          hn_r <= k_r;
          hent_r <= head;
        end
      end
    end
    if (state_r == S_DECIDE) begin
      tgt_r <= d_tgt;
      new_r <= d_new;
      out_event_res <= d_ev;
      out_sequence_res <= seq_r;
      out_entry <= d_tgt;
      out_node_id <= d_new.id;
      out_node_token <= d_new.token;
      out_is_ready <= d_new.ready;
      out_firmware <= d_new.fw;
      out_capabilities <= d_new.caps;
      out_entries_used <= d_add ? fill_r + 6'd1 : fill_r;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 6'(NODE_SLOTS)) else $error("fill count beyond table size");
  a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && k_r == SLOT_W'(NODE_SLOTS - 1)) |=> state_r == S_DECIDE)
    else $error("scan did not end after one rotation");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("item taken while result pending");
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != $past(fill_r)) |-> $past(state_r == S_DECIDE))
    else $error("fill count changed outside decision");

endmodule

// ===== src/node_discovery_id_assigner_unit.sv =====
// Top level of the node discovery id assigner: a ring of table cells and
// the head sequencer. Depends on nda_pkg, nda_cell and nda_ctrl.
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    kind, frame_id, frame_len, byte0..7, slot
//  out      output     out_valid / out_ready  event_res .. entries_used
//  cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A query item goes straight to its result, and a frame that matches nothing is dropped with
// no table scan. A table scan is one full rotation of the 32-cell ring, and writing an entry
// back costs a second rotation. Reset is synchronous; the table holds no reset. One item
// is in work at a time, and a held result stalls the input until it is taken.
module node_discovery_id_assigner_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [10:0] in_frame_id,
  input  logic [3:0]  in_frame_len,
  input  logic [7:0]  in_byte0,
  input  logic [7:0]  in_byte1,
  input  logic [7:0]  in_byte2,
  input  logic [7:0]  in_byte3,
  input  logic [7:0]  in_byte4,
  input  logic [7:0]  in_byte5,
  input  logic [7:0]  in_byte6,
  input  logic [7:0]  in_byte7,
  input  logic [4:0]  in_slot,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_res,
  output logic [7:0]  out_sequence_res,
  output logic [4:0]  out_entry,
  output logic [5:0]  out_node_id,
  output logic [15:0] out_node_token,
  output logic        out_is_ready,
  output logic [7:0]  out_firmware,
  output logic [7:0]  out_capabilities,
  output logic [5:0]  out_entries_used
);
  import nda_pkg::*;

  entry_t cells [NODE_SLOTS];
  entry_t head_in;
  logic shift_en;

  for (genvar i = 0; i < NODE_SLOTS; i++) begin : g_ring
    if (i == NODE_SLOTS - 1) begin : g_last
      nda_cell u_cell (.clk(clk), .shift_en(shift_en), .d_in(head_in), .q(cells[i]));
    end else begin : g_mid
      nda_cell u_cell (.clk(clk), .shift_en(shift_en), .d_in(cells[i+1]), .q(cells[i]));
    end
  end

  nda_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_frame_id(in_frame_id), .in_frame_len(in_frame_len),
    .in_byte0(in_byte0), .in_byte1(in_byte1), .in_byte2(in_byte2), .in_byte3(in_byte3),
    .in_byte4(in_byte4), .in_byte5(in_byte5), .in_byte6(in_byte6), .in_byte7(in_byte7),
    .in_slot(in_slot),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .head(cells[0]), .head_in(head_in), .shift_en(shift_en),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_event_res(out_event_res), .out_sequence_res(out_sequence_res),
    .out_entry(out_entry), .out_node_id(out_node_id),
    .out_node_token(out_node_token), .out_is_ready(out_is_ready),
    .out_firmware(out_firmware), .out_capabilities(out_capabilities),
    .out_entries_used(out_entries_used)
  );

endmodule
